### hdl/pnsh_pkg.sv
// Shared types and constants for the polyline nearest segment hit unit.
// Used by the controller, the datapath and the top level.
`default_nettype none
package pnsh_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int SQ_W    = 34;
    localparam int ROOT_W  = 17;
    localparam int SREM_W  = 20;
    localparam int DREM_W  = 18;
    localparam int IT_W    = 6;
    localparam int TOL_W   = 17;
    localparam int DIST_W  = 17;
    localparam logic [TOL_W-1:0] TOL_RESET = 17'd240;

    typedef enum logic [2:0] {
        REQ_CLEAR   = 3'd0,
        REQ_APPEND  = 3'd1,
        REQ_REPLACE = 3'd2,
        REQ_CLOSE   = 3'd3,
        REQ_QUERY   = 3'd4
    } t_req;

    typedef struct packed {
        logic load;
        logic rd_a;
        logic rd_b;
        logic lat_p;
        logic lat_q;
        logic exec;
        logic classify;
        logic mul1;
        logic sum1;
        logic sqrt_step;
        logic mul2;
        logic sum2;
        logic div_step;
        logic cmp;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic empty;
        logic direct;
        logic in_box;
        logic sqrt_last;
        logic div_last;
        logic seg_last;
    } t_sts;

endpackage
`default_nettype wire

### hdl/pnsh_ctrl.sv
// Controller state machine of the polyline nearest segment hit unit.
// Depends on pnsh_pkg; drives commands to pnsh_dp and reads its status.
`default_nettype none
module pnsh_ctrl import pnsh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_RD0   = 15'b000000000000010,
        S_RD1   = 15'b000000000000100,
        S_RD2   = 15'b000000000001000,
        S_EXEC  = 15'b000000000010000,
        S_CLASS = 15'b000000000100000,
        S_MUL1  = 15'b000000001000000,
        S_SUM1  = 15'b000000010000000,
        S_SQRT  = 15'b000000100000000,
        S_MUL2  = 15'b000001000000000,
        S_SUM2  = 15'b000010000000000,
        S_DIV   = 15'b000100000000000,
        S_CMP   = 15'b001000000000000,
        S_FIN   = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_b  = 1'b1;
                o_cmd.lat_p = 1'b1;
                n_state     = S_RD2;
            end
            S_RD2: begin
                o_cmd.lat_q = 1'b1;
                if (!i_sts.is_query) begin
                    n_state = S_EXEC;
                end else if (i_sts.empty) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CLASS;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FIN;
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = i_sts.direct ? S_CMP : S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_SUM1;
            end
            S_SUM1: begin
                o_cmd.sum1 = 1'b1;
                n_state    = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) begin
                    n_state = i_sts.in_box ? S_MUL2 : S_CMP;
                end
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_SUM2;
            end
            S_SUM2: begin
                o_cmd.sum2 = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = i_sts.seg_last ? S_FIN : S_RD0;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/pnsh_dp.sv
// Datapath of the polyline nearest segment hit unit: point store, shared
// multipliers, bit-serial square root and divider, best-segment tracking.
// Depends on pnsh_pkg; commanded by pnsh_ctrl.
`default_nettype none
module pnsh_dp import pnsh_pkg::*; #(
    parameter int MAX_POINTS = 256,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    output t_sts                           o_sts,
    input  wire logic [2:0]                i_req_type,
    input  wire logic signed [COORD_W-1:0] i_x_coord,
    input  wire logic signed [COORD_W-1:0] i_y_coord,
    input  wire logic [TOL_W-1:0]          i_tolerance,
    output logic                           o_hit,
    output logic [7:0]                     o_segment_index,
    output logic [DIST_W-1:0]              o_distance,
    output logic [8:0]                     o_point_count,
    output logic                           o_path_valid,
    output logic                           o_dropped
);

    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [CW-1:0] TWO_C  = CW'(2);
    localparam logic [CW-1:0] FULL_C = CW'(MAX_POINTS);

    logic [31:0]          r_mem [MAX_POINTS];
    logic [31:0]          r_rd;
    logic [2:0]           r_req;
    logic signed [COORD_W-1:0] r_tx, r_ty;
    logic [CW-1:0]        r_cnt;
    logic [31:0]          r_p, r_q;
    logic [IW-1:0]        r_i;
    logic                 r_found;
    logic [IW-1:0]        r_best_i;
    logic [SQ_W-1:0]      r_best_d;
    logic                 r_dropped;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_ex, r_ey;
    logic                 r_inside, r_vert;
    logic [DIFF_W-1:0]    r_vd;
    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic [SQ_W-1:0]      r_sqv;
    logic [SREM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [SQ_W-1:0]      r_dvd;
    logic [DREM_W-1:0]    r_drem;
    logic [IT_W-1:0]      r_it;

    logic [31:0]   w_pin;
    logic          w_full;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [CW-1:0] w_cnt;
    logic          w_drop;
    logic [IW-1:0] w_raddr, w_adda, w_addb, w_j;
    logic [CW-1:0] w_ip1;
    logic signed [COORD_W-1:0] w_x1, w_y1, w_x2, w_y2;
    logic          w_inside, w_vert;
    logic signed [DIFF_W-1:0] w_ma1, w_mb1, w_ma2, w_mb2;
    logic signed [PROD_W:0]   w_cross;
    logic [PROD_W:0]          w_across;
    logic [SREM_W-1:0] w_rem_s, w_trial;
    logic [DREM_W-1:0] w_drem_s, w_div;
    logic [SQ_W-1:0]   w_d;
    logic              w_cand;

    assign w_pin = {r_tx, r_ty};
    assign w_full = (r_cnt == FULL_C);
    assign w_ip1 = CW'(r_i) + ONE_C;
    assign w_j = (w_ip1 < r_cnt) ? IW'(w_ip1) : '0;

    always_comb begin
        case (t_req'(r_req))
            REQ_APPEND:  w_adda = IW'(r_cnt - ONE_C);
            REQ_REPLACE: w_adda = IW'(r_cnt - TWO_C);
            REQ_CLOSE:   w_adda = '0;
            default:     w_adda = r_i;
        endcase
        case (t_req'(r_req))
            REQ_QUERY: w_addb = w_j;
            default:   w_addb = IW'(r_cnt - ONE_C);
        endcase
        w_raddr = i_cmd.rd_b ? w_addb : w_adda;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = IW'(r_cnt);
        w_wdata = w_pin;
        w_cnt   = r_cnt;
        w_drop  = 1'b0;
        case (t_req'(r_req))
            REQ_CLEAR: begin
                w_cnt = '0;
            end
            REQ_APPEND: begin
                if (r_cnt == '0 || r_p != w_pin) begin
                    if (w_full) begin
                        w_drop = 1'b1;
                    end else begin
                        w_we  = 1'b1;
                        w_cnt = r_cnt + ONE_C;
                    end
                end
            end
            REQ_REPLACE: begin
                if (r_cnt != '0 && !(r_cnt > ONE_C && r_p == w_pin)) begin
                    w_we    = 1'b1;
                    w_waddr = IW'(r_cnt - ONE_C);
                end
            end
            REQ_CLOSE: begin
                if (r_cnt > ONE_C) begin
                    if (r_p != r_q) begin
                        w_wdata = r_p;
                        if (w_full) begin
                            w_drop = 1'b1;
                        end else begin
                            w_we  = 1'b1;
                            w_cnt = r_cnt + ONE_C;
                        end
                    end
                end else begin
                    w_cnt = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    // segment geometry
    assign w_x1 = r_p[31:16];
    assign w_y1 = r_p[15:0];
    assign w_x2 = r_q[31:16];
    assign w_y2 = r_q[15:0];
    assign w_inside = (r_tx >= ((w_x1 < w_x2) ? w_x1 : w_x2)) &&
                      (r_tx <= ((w_x1 < w_x2) ? w_x2 : w_x1)) &&
                      (r_ty >= ((w_y1 < w_y2) ? w_y1 : w_y2)) &&
                      (r_ty <= ((w_y1 < w_y2) ? w_y2 : w_y1));
    assign w_vert = (w_x1 == w_x2);

    always_comb begin
        if (i_cmd.mul2) begin
            w_ma1 = r_dx;
            w_mb1 = r_ey;
            w_ma2 = r_dy;
            w_mb2 = r_ex;
        end else if (r_inside) begin
            w_ma1 = r_dx;
            w_mb1 = r_dx;
            w_ma2 = r_dy;
            w_mb2 = r_dy;
        end else begin
            w_ma1 = r_ex;
            w_mb1 = r_ex;
            w_ma2 = r_ey;
            w_mb2 = r_ey;
        end
    end

    assign w_cross  = {r_p1[PROD_W-1], r_p1} - {r_p2[PROD_W-1], r_p2};
    assign w_across = w_cross[PROD_W] ? (PROD_W+1)'(-w_cross) : w_cross;

    assign w_rem_s = {r_rem[SREM_W-3:0], r_sqv[SQ_W-1:SQ_W-2]};
    assign w_trial = SREM_W'({r_root, 2'b01});
    assign w_drem_s = {r_drem[DREM_W-2:0], r_dvd[SQ_W-1]};
    assign w_div = {1'b0, r_root};

    always_comb begin
        if (r_inside && r_vert) begin
            w_d = SQ_W'(r_vd);
        end else if (r_inside) begin
            w_d = r_dvd;
        end else begin
            w_d = SQ_W'(r_root);
        end
    end
    assign w_cand = r_inside || (w_d < SQ_W'(i_tolerance));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.exec) begin
            r_cnt <= w_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_tx      <= i_x_coord;
            r_ty      <= i_y_coord;
            r_i       <= '0;
            r_found   <= 1'b0;
            r_best_i  <= '0;
            r_best_d  <= '0;
            r_dropped <= 1'b0;
        end
        if (i_cmd.lat_p) begin
            r_p <= r_rd;
        end
        if (i_cmd.lat_q) begin
            r_q <= r_rd;
        end
        if (i_cmd.exec) begin
            r_dropped <= w_drop;
        end
        if (i_cmd.classify) begin
            r_dx     <= DIFF_W'(w_x2) - DIFF_W'(w_x1);
            r_dy     <= DIFF_W'(w_y2) - DIFF_W'(w_y1);
            r_ex     <= DIFF_W'(r_tx) - DIFF_W'(w_x1);
            r_ey     <= DIFF_W'(r_ty) - DIFF_W'(w_y1);
            r_inside <= w_inside;
            r_vert   <= w_vert;
            r_vd     <= (r_tx >= w_x1) ? DIFF_W'(DIFF_W'(r_tx) - DIFF_W'(w_x1))
                                       : DIFF_W'(DIFF_W'(w_x1) - DIFF_W'(r_tx));
        end
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_p1 <= w_ma1 * w_mb1;
            r_p2 <= w_ma2 * w_mb2;
        end
        if (i_cmd.sum1) begin
            r_sqv  <= SQ_W'(r_p1) + SQ_W'(r_p2);
            r_rem  <= '0;
            r_root <= '0;
            r_it   <= '0;
        end
        if (i_cmd.sqrt_step) begin
            if (w_rem_s >= w_trial) begin
                r_rem  <= w_rem_s - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_s;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
            r_sqv <= {r_sqv[SQ_W-3:0], 2'b00};
            r_it  <= r_it + IT_W'(1);
        end
        if (i_cmd.sum2) begin
            r_dvd  <= w_across[SQ_W-1:0];
            r_drem <= '0;
            r_it   <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_drem_s >= w_div) begin
                r_drem <= w_drem_s - w_div;
                r_dvd  <= {r_dvd[SQ_W-2:0], 1'b1};
            end else begin
                r_drem <= w_drem_s;
                r_dvd  <= {r_dvd[SQ_W-2:0], 1'b0};
            end
            r_it <= r_it + IT_W'(1);
        end
        if (i_cmd.cmp) begin
            if (w_cand && (!r_found || w_d < r_best_d)) begin
                r_found  <= 1'b1;
                r_best_i <= r_i;
                r_best_d <= w_d;
            end
            r_i <= IW'(w_ip1);
        end
        if (i_cmd.fin) begin
            o_hit           <= r_found;
            o_segment_index <= 8'(r_best_i);
            o_distance      <= (r_best_d > SQ_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                                  : r_best_d[DIST_W-1:0];
            o_point_count   <= 9'(r_cnt);
            o_path_valid    <= (r_cnt > CW'(3));
            o_dropped       <= r_dropped;
        end
    end

    assign o_sts.is_query  = (t_req'(r_req) == REQ_QUERY);
    assign o_sts.empty     = (r_cnt == '0);
    assign o_sts.direct    = w_inside && w_vert;
    assign o_sts.in_box    = r_inside;
    assign o_sts.sqrt_last = (r_it == IT_W'(ROOT_W - 1));
    assign o_sts.div_last  = (r_it == IT_W'(SQ_W - 1));
    assign o_sts.seg_last  = (CW'(r_i) == (r_cnt - ONE_C));

endmodule
`default_nettype wire

### hdl/polyline_nearest_segment_hit_unit.sv
// Polyline nearest segment hit unit: point store with clear, append, replace,
// close and nearest-segment query. Top level; depends on pnsh_pkg,
// pnsh_ctrl and pnsh_dp.
//
// Input channel: i_valid / o_stall with i_req_type, i_x_coord, i_y_coord.
// Output channel: o_valid / i_stall, one result item per input item.
// Config channel: i_cfg_valid / o_cfg_ready writes the 17-bit tolerance;
// ready is always high.
// One item is worked at a time; o_stall stays high from acceptance until
// the result is taken. An edit item passes the reads, the edit and a
// finish step before its result shows.
// A query on an empty path goes from the reads to the finish step. Otherwise
// it takes, per segment, reads, classify and compare and, between them:
// nothing for an in-box vertical segment; multiply, sum and a 17-step square
// root outside the box; or square root, second multiply and a 34-step
// divider inside it; a finish step after the last segment gives the result.
// Reset clears the point count and the tolerance goes to 240; the point
// memory is not cleared. A stalled result holds on the output ports.
`default_nettype none
module polyline_nearest_segment_hit_unit import pnsh_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [2:0]                i_req_type,
    input  wire logic signed [COORD_W-1:0] i_x_coord,
    input  wire logic signed [COORD_W-1:0] i_y_coord,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_hit,
    output logic [7:0]                     o_segment_index,
    output logic [DIST_W-1:0]              o_distance,
    output logic [8:0]                     o_point_count,
    output logic                           o_path_valid,
    output logic                           o_dropped,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [TOL_W-1:0]          i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic [TOL_W-1:0] r_tolerance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tolerance <= i_cfg_data;
        end
    end

    pnsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pnsh_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_req_type      (i_req_type),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_tolerance     (r_tolerance),
        .o_hit           (o_hit),
        .o_segment_index (o_segment_index),
        .o_distance      (o_distance),
        .o_point_count   (o_point_count),
        .o_path_valid    (o_path_valid),
        .o_dropped       (o_dropped)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("accepted item did not make the unit busy");

    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while input side open");

    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_distance == '0 && o_segment_index == '0))
        else $error("miss result carries distance or index");
`endif

endmodule
`default_nettype wire

### tb/polyline_nearest_segment_hit_unit_tb.sv
// Testbench for polyline_nearest_segment_hit_unit: directed and random path edits and
// queries, checked against an in-bench predictor held by a small scoreboard class.
// Depends on pnsh_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module polyline_nearest_segment_hit_unit_tb;
    import pnsh_pkg::*;

    localparam int NPTS = 256;
    localparam int LIMIT = 20000000;
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam logic [DIST_W-1:0] DIST_SAT = 17'h1FFFF;

    typedef struct {
        bit hit;
        bit [7:0] seg;
        bit [DIST_W-1:0] distance;
        bit [8:0] count;
        bit path_valid;
        bit dropped;
    } t_outcome;

    class path_scoreboard;
        bit [31:0] pts[NPTS];
        int unsigned npts;
        bit [TOL_W-1:0] tol;
        t_outcome due[$];
        int fails;

        function new();
            npts = 0;
            tol = TOL_RESET;
            fails = 0;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        function longint px(bit [31:0] p);
            return longint'($signed(p[31:16]));
        endfunction

        function longint py(bit [31:0] p);
            return longint'($signed(p[15:0]));
        endfunction

        function bit add_point(bit [31:0] p);
            if (npts >= NPTS) return 1'b1;
            pts[npts] = p;
            npts++;
            return 1'b0;
        endfunction

        function void nearest(longint tx, longint ty, ref t_outcome o);
            bit found, cand;
            int unsigned j, best_i;
            longint x1, y1, x2, y2, lox, hix, loy, hiy, dx, dy, cr;
            longint unsigned d, best_d;
            found = 0;
            best_i = 0;
            best_d = 0;
            for (int unsigned i = 0; i < npts; i++) begin
                j = (i + 1 < npts) ? i + 1 : 0;
                x1 = px(pts[i]); y1 = py(pts[i]);
                x2 = px(pts[j]); y2 = py(pts[j]);
                lox = x1 < x2 ? x1 : x2; hix = x1 < x2 ? x2 : x1;
                loy = y1 < y2 ? y1 : y2; hiy = y1 < y2 ? y2 : y1;
                if (tx >= lox && tx <= hix && ty >= loy && ty <= hiy) begin
                    if (x1 == x2) begin
                        d = mag(tx - x1);
                    end else begin
                        dx = x2 - x1;
                        dy = y2 - y1;
                        cr = dx * (ty - y1) - dy * (tx - x1);
                        d = mag(cr) / isqrt(longint'(dx * dx + dy * dy));
                    end
                    cand = 1;
                end else begin
                    d = isqrt(longint'((tx - x1) * (tx - x1) + (ty - y1) * (ty - y1)));
                    cand = d < tol;
                end
                if (cand && (!found || d < best_d)) begin
                    found = 1;
                    best_i = i;
                    best_d = d;
                end
            end
            if (found) begin
                o.hit = 1;
                o.seg = best_i[7:0];
                o.distance = best_d > DIST_SAT ? DIST_SAT : best_d[DIST_W-1:0];
            end
        endfunction

        function void note_item(logic [2:0] req, logic signed [15:0] x, logic signed [15:0] y);
            t_outcome o;
            bit [31:0] p;
            o = '{default: 0};
            p = {x, y};
            case (req)
                REQ_CLEAR: npts = 0;
                REQ_APPEND: begin
                    if (npts == 0 || pts[npts-1] != p) o.dropped = add_point(p);
                end
                REQ_REPLACE: begin
                    if (npts > 0 && !(npts > 1 && pts[npts-2] == p)) pts[npts-1] = p;
                end
                REQ_CLOSE: begin
                    if (npts > 1) begin
                        if (pts[0] != pts[npts-1]) o.dropped = add_point(pts[0]);
                    end else begin
                        npts = 0;
                    end
                end
                REQ_QUERY: nearest(longint'(x), longint'(y), o);
                default: ;
            endcase
            o.count = npts[8:0];
            o.path_valid = npts > 3;
            due = {due, o};
        endfunction

        function void check_result(t_outcome got);
            t_outcome e;
            if (due.size() == 0) begin
                $error("result with nothing expected");
                fails++;
                return;
            end
            e = due.pop_front();
            if (got.hit != e.hit) begin
                $error("hit: expected %0d actual %0d", e.hit, got.hit); fails++;
            end
            if (got.seg != e.seg) begin
                $error("segment_index: expected %0d actual %0d", e.seg, got.seg); fails++;
            end
            if (got.distance != e.distance) begin
                $error("distance: expected %0d actual %0d", e.distance, got.distance);
                fails++;
            end
            if (got.count != e.count) begin
                $error("point_count: expected %0d actual %0d", e.count, got.count); fails++;
            end
            if (got.path_valid != e.path_valid) begin
                $error("path_valid: expected %0d actual %0d", e.path_valid, got.path_valid);
                fails++;
            end
            if (got.dropped != e.dropped) begin
                $error("dropped: expected %0d actual %0d", e.dropped, got.dropped); fails++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic [2:0] i_req_type;
    logic signed [COORD_W-1:0] i_x_coord, i_y_coord;
    logic o_hit, o_path_valid, o_dropped, i_cfg_valid, o_cfg_ready;
    logic [7:0] o_segment_index;
    logic [DIST_W-1:0] o_distance;
    logic [8:0] o_point_count;
    logic [TOL_W-1:0] i_cfg_data;

    path_scoreboard sb;
    bit valid_up;
    bit send_burst, take_burst, hold_long;

    polyline_nearest_segment_hit_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hit(o_hit), .o_segment_index(o_segment_index), .o_distance(o_distance),
        .o_point_count(o_point_count), .o_path_valid(o_path_valid), .o_dropped(o_dropped),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    task automatic send_item(logic [2:0] req, logic signed [15:0] x, logic signed [15:0] y);
        int gap;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            if (valid_up) i_valid <= 0;
            valid_up = 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        valid_up = 1;
        i_req_type <= req;
        i_x_coord <= x;
        i_y_coord <= y;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(req, x, y);
    endtask

    task automatic drain();
        if (valid_up) i_valid <= 0;
        valid_up = 0;
        while (sb.due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.tol = v;
    endtask

    function automatic logic signed [15:0] near(int c, int spread);
        int v;
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    initial begin
        t_outcome got;
        int n;
        i_stall <= 1;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
            n = take_burst ? 0 : $urandom_range(0, 17);
            if (hold_long) begin
                n = 400;
                hold_long = 0;
            end
            if (n > 0) begin
                i_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 0;
            do @(posedge i_clk); while (!o_valid);
            got.hit = o_hit;
            got.seg = o_segment_index;
            got.distance = o_distance;
            got.count = o_point_count;
            got.path_valid = o_path_valid;
            got.dropped = o_dropped;
            sb.check_result(got);
        end
    end

    initial begin
        int kind, k, cx, cy, items;
        logic signed [15:0] lx, ly;
        sb = new();
        i_rst_n <= 0;
        i_valid <= 0;
        i_req_type <= REQ_CLEAR;
        i_x_coord <= 0;
        i_y_coord <= 0;
        i_cfg_valid <= 0;
        i_cfg_data <= 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed edge cases
        send_item(REQ_QUERY, 16'sd0, 16'sd0);
        send_item(REQ_REPLACE, 16'sd5, 16'sd5);
        send_item(REQ_CLOSE, 16'sd0, 16'sd0);
        send_item(REQ_APPEND, 16'sd100, -16'sd100);
        send_item(REQ_QUERY, 16'sd100, -16'sd100);
        send_item(REQ_CLOSE, 16'sd0, 16'sd0);
        send_item(REQ_APPEND, 16'sd100, -16'sd100);
        send_item(REQ_APPEND, 16'sd100, -16'sd100);
        send_item(REQ_APPEND, -16'sd32768, -16'sd32768);
        send_item(REQ_APPEND, 16'sd32767, 16'sd32767);
        send_item(REQ_REPLACE, -16'sd32768, -16'sd32768);
        send_item(REQ_REPLACE, 16'sd32767, -16'sd32768);
        send_item(REQ_APPEND, 16'sd32767, 16'sd32767);
        send_item(REQ_QUERY, 16'sd32767, 16'sd0);
        send_item(REQ_QUERY, -16'sd32768, 16'sd32767);
        send_item(REQ_CLOSE, 16'sd0, 16'sd0);
        send_item(REQ_CLOSE, 16'sd0, 16'sd0);
        send_item(REQ_QUERY, 16'sd0, 16'sd0);
        send_item(REQ_SPARE_LO, -16'sd1, 16'sd1);
        send_item(REQ_SPARE_HI, 16'sd1, -16'sd1);
        write_tolerance('0);
        send_item(REQ_QUERY, -16'sd32768, 16'sd32767);
        write_tolerance(17'h1FFFF);
        send_item(REQ_QUERY, -16'sd32768, 16'sd32767);
        send_item(REQ_CLEAR, 16'sd0, 16'sd0);

        // fill the store, overflow append and close
        write_tolerance(17'd64);
        for (int i = 0; i < NPTS; i++) send_item(REQ_APPEND, 16'(i * 16), 16'((i % 7) * 16));
        send_item(REQ_APPEND, 16'sd5, 16'sd5);
        send_item(REQ_CLOSE, 16'sd0, 16'sd0);
        send_item(REQ_QUERY, 16'sd2000, 16'sd40);
        send_item(REQ_CLEAR, 16'sd0, 16'sd0);

        // back-pressure: receiver holds off while items keep coming
        hold_long = 1;
        send_burst = 1;
        for (int i = 0; i < 6; i++) send_item(REQ_APPEND, 16'(i * 40), 16'(i * 24));
        send_item(REQ_QUERY, 16'sd60, 16'sd30);
        drain();
        send_burst = 0;

        items = 0;
        while (items < 100) begin
            if ($urandom_range(0, 7) == 0)
                write_tolerance(TOL_W'($urandom_range(0, 3) == 0
                                       ? $urandom_range(0, 17'h1FFFF)
                                       : $urandom_range(0, 1200)));
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_item(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
                items++;
            end else begin
                cx = $urandom_range(0, 60000) - 30000;
                cy = $urandom_range(0, 60000) - 30000;
                send_item(REQ_CLEAR, 16'sd0, 16'sd0);
                items++;
                k = $urandom_range(1, 12);
                lx = near(cx, 1024);
                ly = near(cy, 1024);
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(0, 5) != 0) begin
                        lx = $urandom_range(0, 3) == 0 ? lx : near(cx, 1024);
                        ly = near(cy, 1024);
                    end
                    send_item(REQ_APPEND, lx, ly);
                    items++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_item(REQ_REPLACE, near(cx, 1024), near(cy, 1024));
                    items++;
                end
                if ($urandom_range(0, 1) == 0) begin
                    send_item(REQ_CLOSE, 16'($urandom), 16'($urandom));
                    items++;
                end
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) begin
                    send_item(REQ_QUERY, near(cx, $urandom_range(0, 1) ? 300 : 4000),
                              near(cy, $urandom_range(0, 1) ? 300 : 4000));
                    items++;
                end
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.fails == 0 && sb.due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### filelist.f
hdl/pnsh_pkg.sv
hdl/pnsh_ctrl.sv
hdl/pnsh_dp.sv
hdl/polyline_nearest_segment_hit_unit.sv
tb/polyline_nearest_segment_hit_unit_tb.sv
